// ===== hdl/llas_pkg.sv =====
package llas_pkg;

  // Line store depth and the widths that follow from it
  localparam int MAX_COLS   = 512;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int AGE_LEVELS = 8;

  localparam int AGE_W  = 3;
  localparam int ROW_W  = 12;
  localparam int COLS_W = 10;
  localparam int CFG_W  = 12;

  // Highest age in color mode: min(AGE_LEVELS-1, 7)
  localparam logic [AGE_W-1:0] TOP_AGE =
    (AGE_LEVELS - 1 > 7) ? AGE_W'(7) : AGE_W'(AGE_LEVELS - 1);

  // Configuration register indexes
  localparam logic [1:0] REG_RULE  = 2'd0;
  localparam logic [1:0] REG_COLOR = 2'd1;
  localparam logic [1:0] REG_ROWS  = 2'd2;
  localparam logic [1:0] REG_COLS  = 2'd3;

  // Rule codes
  localparam logic [1:0] RULE_LIFE   = 2'd0;
  localparam logic [1:0] RULE_CORAL  = 2'd1;
  localparam logic [1:0] RULE_AMOEBA = 2'd2;
  localparam logic [1:0] RULE_MAZE   = 2'd3;

  // One window column: top, middle and bottom row ages
  typedef struct packed {
    logic [AGE_W-1:0] top;
    logic [AGE_W-1:0] mid;
    logic [AGE_W-1:0] bot;
  } age_col_t;

  // Per-transaction control carried down the pipeline
  typedef struct packed {
    logic shift;
    logic emit;
    logic interior;
    logic last;
  } item_ctrl_t;

  // Next age of the center cell of a 3x3 window
  function automatic logic [AGE_W-1:0] next_age(input logic [1:0] rule,
                                                input logic       color,
                                                input age_col_t   lft,
                                                input age_col_t   ctr,
                                                input age_col_t   rgt);
    logic [3:0] n;
    logic       alive;
    logic       keep;
    n = 4'((lft.top != '0)) + 4'((lft.mid != '0)) + 4'((lft.bot != '0)) +
        4'((ctr.top != '0)) + 4'((ctr.bot != '0)) +
        4'((rgt.top != '0)) + 4'((rgt.mid != '0)) + 4'((rgt.bot != '0));
    alive = (ctr.mid != '0);
    case (rule)
      RULE_LIFE:   keep = alive ? (n inside {4'd2, 4'd3}) : (n == 4'd3);
      RULE_CORAL:  keep = alive ? (n > 4'd3) : (n == 4'd3);
      RULE_AMOEBA: keep = alive ? (n inside {4'd1, 4'd3, 4'd5, 4'd8})
                                : (n inside {4'd3, 4'd5, 4'd7});
      RULE_MAZE:   keep = alive ? (n inside {[4'd1:4'd5]}) : (n == 4'd3);
      default:     keep = 1'b0;
    endcase
    if (!keep) begin
      next_age = '0;
    end else if (!color) begin
      next_age = AGE_W'(1);
    end else if (ctr.mid < TOP_AGE) begin
      next_age = ctr.mid + AGE_W'(1);
    end else begin
      next_age = ctr.mid;
    end
  endfunction

endpackage

// ===== hdl/llas_cell.sv =====
// One column of the 3x3 window; takes its neighbor's column on each shift
module llas_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  llas_pkg::age_col_t col_in,
  output llas_pkg::age_col_t col_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

endmodule

// ===== hdl/llas_lines.sv =====
// Upper and middle line stores with registered read and a clearing pass
module llas_lines (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [llas_pkg::COL_W-1:0]   rd_addr,
  output logic [llas_pkg::AGE_W-1:0]   rd_up,
  output logic [llas_pkg::AGE_W-1:0]   rd_mid,
  input  logic                         wr_en,
  input  logic [llas_pkg::COL_W-1:0]   wr_addr,
  input  logic [llas_pkg::AGE_W-1:0]   wr_up,
  input  logic [llas_pkg::AGE_W-1:0]   wr_mid,
  output logic                         busy
);

  logic [llas_pkg::AGE_W-1:0] upper  [llas_pkg::MAX_COLS];
  logic [llas_pkg::AGE_W-1:0] middle [llas_pkg::MAX_COLS];
  logic                       clearing;
  logic [llas_pkg::COL_W-1:0] clr_addr;
  logic                       wr_hit;

  assign busy   = clearing;
  assign wr_hit = wr_en && (wr_addr == rd_addr);

  // Clearing pass after reset, one entry of each store per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == llas_pkg::COL_W'(llas_pkg::MAX_COLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      upper[clr_addr]  <= '0;
      middle[clr_addr] <= '0;
    end else if (wr_en) begin
      upper[wr_addr]  <= wr_up;
      middle[wr_addr] <= wr_mid;
    end
  end

  // Read port; a write to the same entry in this cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_up  <= wr_hit ? wr_up  : upper[rd_addr];
      rd_mid <= wr_hit ? wr_mid : middle[rd_addr];
    end
  end

endmodule

// ===== hdl/life_like_automaton_stream.sv =====
// Life-like cellular automaton, one generation over a raster stream.
// Cell channel (cell_valid / cell_stall): one cell age per transaction in
// raster order; operation 1 is a flush item that drains the frame tail.
// Result channel (result_valid / result_stall): the new age of the cell
// one row and one column behind the input, frame_last on the frame's final
// cell. A frame of R x C cells needs C+1 flush items after its last cell.
// Throughput: one transaction per clock unless cell_stall is high; the window
// is three column cells that shift once per item bringing a new column, and
// the line stores take one read and one write per cycle. Each result passes
// stage 1, stage 2 and the result register. Configuration (cfg_we, cfg_index,
// cfg_data) is written by the user only while idle, unenforced by the block.
// Reset: clears counters, window, configuration and valid flags; a clearing
// pass then zeroes both line stores, with cell_stall held high meanwhile.
// When the receiver stalls a valid result, the result register holds and the
// pipeline freezes; cell_stall rises in the same cycle until the result is taken.
module life_like_automaton_stream (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [llas_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               cell_valid,
  output logic                               cell_stall,
  input  logic                               operation,
  input  logic [llas_pkg::AGE_W-1:0]         cell_age,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [llas_pkg::AGE_W-1:0]         new_age,
  output logic                               frame_last
);

  localparam int ROW_W = llas_pkg::ROW_W;
  localparam int COL_W = llas_pkg::COL_W;
  localparam int AGE_W = llas_pkg::AGE_W;

  // Configuration registers
  logic [1:0]                  rule_select;
  logic                        color_mode;
  logic [ROW_W-1:0]            rows_in_use;
  logic [llas_pkg::COLS_W-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_select <= llas_pkg::RULE_LIFE;
      color_mode  <= 1'b0;
      rows_in_use <= ROW_W'(400);
      cols_in_use <= llas_pkg::COLS_W'(420);
    end else if (cfg_we) begin
      case (cfg_index)
        llas_pkg::REG_RULE:  rule_select <= cfg_data[1:0];
        llas_pkg::REG_COLOR: color_mode  <= cfg_data[0];
        llas_pkg::REG_ROWS:  rows_in_use <= cfg_data[ROW_W-1:0];
        llas_pkg::REG_COLS:  cols_in_use <= cfg_data[llas_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [ROW_W-1:0]            rows_eff;
  logic [ROW_W-1:0]            rows_m1;
  logic [llas_pkg::COLS_W-1:0] cols_eff;
  logic [COL_W-1:0]            cols_m1;
  logic [llas_pkg::COLS_W-1:0] cols_m1_full;

  always_comb begin
    rows_eff = (rows_in_use < ROW_W'(3)) ? ROW_W'(3) : rows_in_use;
    rows_m1  = rows_eff - 1'b1;
    if (cols_in_use < llas_pkg::COLS_W'(3)) begin
      cols_eff = llas_pkg::COLS_W'(3);
    end else if (cols_in_use > llas_pkg::COLS_W'(llas_pkg::MAX_COLS)) begin
      cols_eff = llas_pkg::COLS_W'(llas_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_in_use;
    end
    cols_m1_full = cols_eff - 1'b1;
    cols_m1      = cols_m1_full[COL_W-1:0];
  end

  // Handshake and pipeline advance
  logic busy;
  logic advance;
  logic accept;

  assign advance    = !(result_valid && result_stall);
  assign cell_stall = busy || !advance;
  assign accept     = cell_valid && !cell_stall;

  // Position counters
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0] out_col, out_col_next;

  logic                 complete;
  logic                 noop;
  llas_pkg::item_ctrl_t ctrl;
  logic [AGE_W-1:0]     age_in;

  // Decide what this transaction does, in the order of a single step
  always_comb begin
    complete     = (in_row >= rows_eff);
    noop         = 1'b0;
    ctrl         = '0;
    age_in       = operation ? '0 : cell_age;
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (complete) begin
      ctrl.emit = 1'b1;
    end else if (operation && in_row == '0 && in_col == '0) begin
      noop = 1'b1;
    end else begin
      ctrl.shift = 1'b1;
      ctrl.emit  = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);
      if (in_col >= cols_m1) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end
    if (ctrl.emit) begin
      ctrl.interior = (out_row != '0) && (out_row < rows_m1) &&
                      (out_col != '0) && (out_col < cols_m1);
      ctrl.last     = (out_row >= rows_m1) && (out_col >= cols_m1);
      if (ctrl.last) begin
        out_row_next = '0;
        out_col_next = '0;
        in_row_next  = '0;
        in_col_next  = '0;
      end else if (out_col >= cols_m1) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // Stage 1: line store data arrives
  logic                 s1_valid;
  llas_pkg::item_ctrl_t s1_ctrl;
  logic [AGE_W-1:0]     s1_age;
  logic [COL_W-1:0]     s1_addr;
  logic [AGE_W-1:0]     rd_up;
  logic [AGE_W-1:0]     rd_mid;
  logic                 shift;

  assign shift = advance && s1_valid && s1_ctrl.shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && !noop;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      s1_ctrl <= ctrl;
      s1_age  <= age_in;
      s1_addr <= in_col;
    end
  end

  llas_lines u_lines (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && ctrl.shift),
    .rd_addr (in_col),
    .rd_up   (rd_up),
    .rd_mid  (rd_mid),
    .wr_en   (shift),
    .wr_addr (s1_addr),
    .wr_up   (rd_mid),
    .wr_mid  (s1_age),
    .busy    (busy)
  );

  // Window: three column cells, new column enters on the right
  llas_pkg::age_col_t new_col;
  llas_pkg::age_col_t col_l, col_c, col_r;

  assign new_col = '{top: rd_up, mid: rd_mid, bot: s1_age};

  llas_cell u_cell_r (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .col_in (new_col),
    .col_q  (col_r)
  );

  llas_cell u_cell_c (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .col_in (col_r),
    .col_q  (col_c)
  );

  llas_cell u_cell_l (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .col_in (col_c),
    .col_q  (col_l)
  );

  // Stage 2: rule evaluation on the updated window
  logic s2_valid;
  logic s2_interior;
  logic s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_interior <= s1_ctrl.interior;
      s2_last     <= s1_ctrl.last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      new_age    <= s2_interior ?
                    llas_pkg::next_age(rule_select, color_mode, col_l, col_c, col_r) :
                    '0;
      frame_last <= s2_last;
    end
  end

endmodule
